// ===== hw/rtl/urs_pkg.sv =====
// ============================================================================
// urs_pkg - shared types and constants of the ultrasonic range sequencer
// Beat payload structs, register indexes, phase encoding and the fixed-point
// constants of the echo-time to distance conversion.
// ============================================================================
package urs_pkg;

   // Field widths fixed by the interface.
   localparam int TICK_BITS      = 10;
   localparam int SPLIT_BITS     = 16;
   localparam int DIST_BITS      = 21;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 21;

   // Parameter defaults for the top level.
   localparam int DEF_TICKS_PER_MS    = 1000;
   localparam int DEF_TRIG_TICKS      = 10;
   localparam int DEF_ECHO_COUNT_BITS = 16;

   // Distance = ticks * SOUND_NUM / SOUND_DEN in units of 0.001 cm. Every
   // echo tick adds a whole part and a remainder part to a running quotient.
   localparam int SOUND_NUM = 34029;
   localparam int SOUND_DEN = 2000;
   localparam int REM_BITS  = 11;
   localparam logic [DIST_BITS-1:0] STEP_Q = DIST_BITS'(SOUND_NUM / SOUND_DEN);
   localparam logic [REM_BITS-1:0]  STEP_R = REM_BITS'(SOUND_NUM % SOUND_DEN);
   localparam logic [REM_BITS-1:0]  REM_DEN = REM_BITS'(SOUND_DEN);
   localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

   // Register reset values and write clamps.
   localparam logic [SPLIT_BITS-1:0] SPLIT_MIN  = SPLIT_BITS'(10);
   localparam logic [DIST_BITS-1:0]  THRESH_MIN = DIST_BITS'(500);

   // Register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPLIT_TIME       = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REPORT_THRESHOLD = CSR_INDEX_BITS'(1);

   typedef enum logic [3:0] {
      PH_IDLE = 4'b0001,
      PH_TRIG = 4'b0010,
      PH_ECHO = 4'b0100,
      PH_GAP  = 4'b1000
   } phase_type;

   typedef struct packed {
      logic echo_level;
      logic run_enable;
   } req_type;

   typedef struct packed {
      logic                 trigger_level;
      logic                 measure_done;
      logic                 report_valid;
      logic [DIST_BITS-1:0] distance;
   } rsp_type;

endpackage

// ===== hw/rtl/ultrasonic_range_sequencer_top.sv =====
// ============================================================================
// ultrasonic_range_sequencer_top - trigger/echo ranging sequencer
// Drives the sensor trigger, times the echo pulse one tick per beat, converts
// the pulse width to distance and reports distances that changed enough.
// ============================================================================
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------
//   req     | in        | req_valid / req_ready | req_data : echo, run (1 tick)
//   rsp     | out       | rsp_valid / rsp_ready | rsp_data : trigger, done,
//           |           |                       |            report, distance
//   csr     | in        | csr_valid / csr_ready | csr_index, csr_data
//
// Every request beat is one microsecond tick and yields exactly one response
// beat, which appears in the cycle after the request is taken. A new request is
// taken in every cycle in which the response register is empty or is being
// emptied, so the block sustains one beat per cycle; the single response
// register is what sets that figure. A stall on the response side holds the
// response and blocks the request side until it drains. Configuration writes
// are always taken. Reset is synchronous and returns the sequencer to idle
// with the register defaults (10 ms gap, threshold 500).
//
module ultrasonic_range_sequencer_top
   import urs_pkg::*;
#(
   parameter int TICKS_PER_MS    = DEF_TICKS_PER_MS,
   parameter int TRIG_TICKS      = DEF_TRIG_TICKS,
   parameter int ECHO_COUNT_BITS = DEF_ECHO_COUNT_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam logic [ECHO_COUNT_BITS-1:0] ECHO_MAX   = {ECHO_COUNT_BITS{1'b1}};
   localparam logic [TICK_BITS-1:0]       TRIG_LIMIT = TICK_BITS'(TRIG_TICKS);
   localparam logic [TICK_BITS-1:0]       MS_LIMIT   = TICK_BITS'(TICKS_PER_MS);

   // Sequencer state.
   phase_type                  phase_ff, phase_in;
   logic [TICK_BITS-1:0]       tick_ff, tick_in;
   logic [SPLIT_BITS-1:0]      ms_ff, ms_in;
   logic [ECHO_COUNT_BITS-1:0] width_ff, width_in;
   logic                       echo_prev_ff, echo_prev_in;
   logic [DIST_BITS-1:0]       last_ff, last_in;

   // The distance of the current echo is kept as a running quotient and
   // remainder of width * SOUND_NUM / SOUND_DEN, so no multiplier or divider
   // is needed: each counted tick adds the constant step.
   logic [DIST_BITS-1:0]       dq_ff, dq_in;
   logic [REM_BITS-1:0]        dr_ff, dr_in;

   // Configuration registers.
   logic [SPLIT_BITS-1:0]      split_ff;
   logic [DIST_BITS-1:0]       thresh_ff;

   // Response register.
   logic                       rsp_valid_ff;
   rsp_type                    rsp_data_ff;
   rsp_type                    rsp_in;

   logic                       req_accept;

   // One step of the running quotient, saturating at the largest distance.
   logic [REM_BITS-1:0]        rem_sum;
   logic                       rem_wrap;
   logic [REM_BITS-1:0]        dr_step;
   logic [DIST_BITS:0]         q_sum;
   logic [DIST_BITS-1:0]       dq_step;

   assign rem_sum  = dr_ff + STEP_R;
   assign rem_wrap = (rem_sum >= REM_DEN);
   assign dr_step  = rem_wrap ? (rem_sum - REM_DEN) : rem_sum;
   assign q_sum    = {1'b0, dq_ff} + {1'b0, STEP_Q} + {{DIST_BITS{1'b0}}, rem_wrap};
   assign dq_step  = q_sum[DIST_BITS] ? DIST_MAX : q_sum[DIST_BITS-1:0];

   // Change detection against the last reported distance.
   logic [DIST_BITS-1:0]       diff;
   logic                       changed;

   assign diff    = (dq_ff > last_ff) ? (dq_ff - last_ff) : (last_ff - dq_ff);
   assign changed = (diff > thresh_ff);

   // The response register frees up in the same cycle it is drained.
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // Next state and response for the tick on the request channel.
   always_comb begin
      phase_in     = phase_ff;
      tick_in      = tick_ff;
      ms_in        = ms_ff;
      width_in     = width_ff;
      dq_in        = dq_ff;
      dr_in        = dr_ff;
      last_in      = last_ff;
      echo_prev_in = req_data.echo_level;
      rsp_in       = '0;

      // A run request in idle starts the trigger pulse on this very tick.
      if (phase_ff == PH_IDLE && req_data.run_enable) begin
         phase_in = PH_TRIG;
         tick_in  = '0;
      end

      case (phase_in)
         PH_TRIG: begin
            rsp_in.trigger_level = 1'b1;
            tick_in              = tick_in + TICK_BITS'(1);
            if (tick_in >= TRIG_LIMIT) begin
               phase_in = PH_ECHO;
               tick_in  = '0;
               width_in = '0;
               dq_in    = '0;
               dr_in    = '0;
            end
         end
         PH_ECHO: begin
            if (req_data.echo_level) begin
               if (!echo_prev_ff) begin
                  // Rising edge: the first high tick is counted.
                  width_in = ECHO_COUNT_BITS'(1);
                  dq_in    = STEP_Q;
                  dr_in    = STEP_R;
               end else if (width_ff != '0 && width_ff < ECHO_MAX) begin
                  width_in = width_ff + ECHO_COUNT_BITS'(1);
                  dq_in    = dq_step;
                  dr_in    = dr_step;
               end
            end else if (echo_prev_ff && width_ff != '0) begin
               // Falling edge of a timed pulse ends the measurement.
               rsp_in.measure_done = 1'b1;
               if (changed) begin
                  rsp_in.report_valid = 1'b1;
                  rsp_in.distance     = dq_ff;
                  last_in             = dq_ff;
               end
               width_in = '0;
               dq_in    = '0;
               dr_in    = '0;
               tick_in  = '0;
               ms_in    = '0;
               phase_in = req_data.run_enable ? PH_GAP : PH_IDLE;
            end
         end
         PH_GAP: begin
            tick_in = tick_in + TICK_BITS'(1);
            if (tick_in >= MS_LIMIT) begin
               tick_in = '0;
               ms_in   = ms_ff + SPLIT_BITS'(1);
               if (ms_in >= split_ff) begin
                  ms_in    = '0;
                  phase_in = req_data.run_enable ? PH_TRIG : PH_IDLE;
               end
            end
         end
         default: begin
            // Idle with run low: nothing moves but the echo history.
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         tick_ff      <= '0;
         ms_ff        <= '0;
         width_ff     <= '0;
         dq_ff        <= '0;
         dr_ff        <= '0;
         echo_prev_ff <= 1'b0;
         last_ff      <= '0;
      end else if (req_accept) begin
         phase_ff     <= phase_in;
         tick_ff      <= tick_in;
         ms_ff        <= ms_in;
         width_ff     <= width_in;
         dq_ff        <= dq_in;
         dr_ff        <= dr_in;
         echo_prev_ff <= echo_prev_in;
         last_ff      <= last_in;
      end
   end

   // Register writes clamp to the minimum legal value.
   always_ff @(posedge clock) begin
      if (reset) begin
         split_ff  <= SPLIT_MIN;
         thresh_ff <= THRESH_MIN;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SPLIT_TIME: begin
               split_ff <= (csr_data[SPLIT_BITS-1:0] < SPLIT_MIN) ?
                           SPLIT_MIN : csr_data[SPLIT_BITS-1:0];
            end
            CSR_REPORT_THRESHOLD: begin
               thresh_ff <= (csr_data[DIST_BITS-1:0] < THRESH_MIN) ?
                            THRESH_MIN : csr_data[DIST_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_in;
      end
   end

endmodule

// ===== hw/rtl/urs_checker.sv =====
// ============================================================================
// urs_checker - port-level checks for the ultrasonic range sequencer
// Watches the top level's ports and is attached to it by a bind statement.
// ============================================================================
module urs_checker
   import urs_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A stalled response beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response beat changed while stalled");

   // An empty response register never blocks a request.
   a_req_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request blocked with empty response register");

   // A report only comes with the end of a measurement.
   a_report_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.report_valid |-> rsp_data.measure_done)
      else $error("report without measurement end");

   // Distance is zero unless reported.
   a_dist_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.report_valid |-> rsp_data.distance == '0)
      else $error("distance nonzero without report");

   // The trigger is never driven on the tick an echo ends.
   a_trig_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.measure_done |-> !rsp_data.trigger_level)
      else $error("trigger high at measurement end");

endmodule

bind ultrasonic_range_sequencer_top urs_checker u_urs_checker (.*);
